@@ rtl/q24_alu_pkg.sv @@
// Shared types and constants for the Q24.8 fixed-point ALU.
package q24_alu_pkg;

   localparam int DATA_W = 32;
   localparam int OP_W   = 4;

   typedef enum logic [OP_W-1:0] {
      OP_ADD      = 4'd0,
      OP_SUB      = 4'd1,
      OP_MUL      = 4'd2,
      OP_DIV      = 4'd3,
      OP_EQ       = 4'd4,
      OP_NE       = 4'd5,
      OP_LT       = 4'd6,
      OP_LE       = 4'd7,
      OP_GT       = 4'd8,
      OP_GE       = 4'd9,
      OP_MIN      = 4'd10,
      OP_MAX      = 4'd11,
      OP_INC      = 4'd12,
      OP_DEC      = 4'd13,
      OP_FROM_INT = 4'd14,
      OP_TO_INT   = 4'd15
   } opcode_type;

   localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

   // Front stage output: simple results done, magnitudes for mul/div.
   typedef struct packed {
      logic              valid;
      opcode_type        op;
      logic [DATA_W-1:0] value;
      logic              cmp;
      logic              err;
      logic              neg;
      logic              a_neg;
      logic              b_zero;
      logic [DATA_W-1:0] mag_a;
      logic [DATA_W-1:0] mag_b;
   } front_type;

   // Per-transaction data riding along the divider stages.
   typedef struct packed {
      opcode_type        op;
      logic [DATA_W-1:0] value;
      logic              cmp;
      logic              err;
      logic              neg;
      logic              a_neg;
      logic              b_zero;
      logic [63:0]       prod;
   } side_type;

endpackage

@@ rtl/q24_alu_if.sv @@
// Request and response channel interfaces.
interface q24_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  opcode;
   logic signed [31:0] operand_a;
   logic signed [31:0] operand_b;
   modport source (output valid, opcode, operand_a, operand_b, input ready);
   modport sink (input valid, opcode, operand_a, operand_b, output ready);
endinterface

interface q24_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [31:0] result_value;
   logic        compare_flag;
   logic        error_flag;
   modport source (output valid, result_value, compare_flag, error_flag, input ready);
   modport sink (input valid, result_value, compare_flag, error_flag, output ready);
endinterface

@@ rtl/q24_front.sv @@
// Front stage: decode, add/sub/compare/min/max/inc/dec/int conversions.
module q24_front
   import q24_alu_pkg::*;
#(
   parameter int FRACTION_BITS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [OP_W-1:0]   opcode,
   input  logic [DATA_W-1:0] operand_a,
   input  logic [DATA_W-1:0] operand_b,
   output front_type         out_ff
);
   localparam int WW = DATA_W + FRACTION_BITS;

   front_type         out_in;
   logic [DATA_W:0]   sum;
   logic [DATA_W:0]   dif;
   logic              lt;
   logic              eq;
   logic [DATA_W-1:0] ma;
   logic [DATA_W-1:0] mb;
   logic [WW-1:0]     wide;
   logic [FRACTION_BITS:0] hi;
   logic              fi_ovf;
   logic [DATA_W-1:0] ti;

   always_comb begin
      ma   = operand_a[DATA_W-1] ? (~operand_a + 1'b1) : operand_a;
      mb   = operand_b[DATA_W-1] ? (~operand_b + 1'b1) : operand_b;
      sum  = {operand_a[DATA_W-1], operand_a} + {operand_b[DATA_W-1], operand_b};
      dif  = {operand_a[DATA_W-1], operand_a} - {operand_b[DATA_W-1], operand_b};
      lt   = $signed(operand_a) < $signed(operand_b);
      eq   = operand_a == operand_b;
      wide = {ma, {FRACTION_BITS{1'b0}}};
      hi   = wide[WW-1:DATA_W-1];
      if (operand_a[DATA_W-1]) begin
         fi_ovf = (hi > 1) || ((hi == 1) && (wide[DATA_W-2:0] != '0));
      end else begin
         fi_ovf = hi != '0;
      end
      ti = ma >> FRACTION_BITS;

      out_in        = '0;
      out_in.valid  = in_valid;
      out_in.op     = opcode_type'(opcode);
      out_in.neg    = operand_a[DATA_W-1] ^ operand_b[DATA_W-1];
      out_in.a_neg  = operand_a[DATA_W-1];
      out_in.b_zero = operand_b == '0;
      out_in.mag_a  = ma;
      out_in.mag_b  = mb;
      case (opcode_type'(opcode))
         OP_ADD: begin
            out_in.err   = sum[DATA_W] != sum[DATA_W-1];
            out_in.value = out_in.err ? (sum[DATA_W] ? SAT_MIN : SAT_MAX) : sum[DATA_W-1:0];
         end
         OP_SUB: begin
            out_in.err   = dif[DATA_W] != dif[DATA_W-1];
            out_in.value = out_in.err ? (dif[DATA_W] ? SAT_MIN : SAT_MAX) : dif[DATA_W-1:0];
         end
         OP_EQ:  out_in.cmp = eq;
         OP_NE:  out_in.cmp = !eq;
         OP_LT:  out_in.cmp = lt;
         OP_LE:  out_in.cmp = lt || eq;
         OP_GT:  out_in.cmp = !(lt || eq);
         OP_GE:  out_in.cmp = !lt;
         OP_MIN: out_in.value = lt ? operand_a : operand_b;
         OP_MAX: out_in.value = lt ? operand_b : operand_a;
         OP_INC: begin
            out_in.err   = operand_a == SAT_MAX;
            out_in.value = out_in.err ? SAT_MAX : operand_a + 1'b1;
         end
         OP_DEC: begin
            out_in.err   = operand_a == SAT_MIN;
            out_in.value = out_in.err ? SAT_MIN : operand_a - 1'b1;
         end
         OP_FROM_INT: begin
            out_in.err = fi_ovf;
            if (fi_ovf) begin
               out_in.value = operand_a[DATA_W-1] ? SAT_MIN : SAT_MAX;
            end else begin
               out_in.value = operand_a[DATA_W-1] ? (~wide[DATA_W-1:0] + 1'b1)
                                                  : wide[DATA_W-1:0];
            end
         end
         OP_TO_INT: out_in.value = operand_a[DATA_W-1] ? (~ti + 1'b1) : ti;
         default: out_in.value = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else if (en) begin
         out_ff.valid <= out_in.valid;
      end
      if (en) begin
         out_ff.op     <= out_in.op;
         out_ff.value  <= out_in.value;
         out_ff.cmp    <= out_in.cmp;
         out_ff.err    <= out_in.err;
         out_ff.neg    <= out_in.neg;
         out_ff.a_neg  <= out_in.a_neg;
         out_ff.b_zero <= out_in.b_zero;
         out_ff.mag_a  <= out_in.mag_a;
         out_ff.mag_b  <= out_in.mag_b;
      end
   end
endmodule

@@ rtl/q24_div_stage.sv @@
// One pipeline stage of the restoring divider, R quotient bits per stage.
module q24_div_stage
   import q24_alu_pkg::*;
#(
   parameter int TW = 44,
   parameter int DW = 33,
   parameter int R  = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          v_in,
   input  side_type      side_in,
   input  logic [DW-1:0] rem_in,
   input  logic [TW-1:0] nq_in,
   input  logic [DW-1:0] den_in,
   output logic          v_ff,
   output side_type      side_ff,
   output logic [DW-1:0] rem_ff,
   output logic [TW-1:0] nq_ff,
   output logic [DW-1:0] den_ff
);
   logic [DW:0]   r;
   logic [TW-1:0] nq;
   logic [DW-1:0] rem_in_w;

   always_comb begin
      r  = {1'b0, rem_in};
      nq = nq_in;
      for (int i = 0; i < R; i++) begin
         r  = {r[DW-1:0], nq[TW-1]};
         nq = {nq[TW-2:0], 1'b0};
         if (r >= {1'b0, den_in}) begin
            r     = r - {1'b0, den_in};
            nq[0] = 1'b1;
         end
      end
      rem_in_w = r[DW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= v_in;
      end
      if (en) begin
         side_ff <= side_in;
         rem_ff  <= rem_in_w;
         nq_ff   <= nq;
         den_ff  <= den_in;
      end
   end
endmodule

@@ rtl/q24_8_fixed_point_alu_core.sv @@
// Top level of the pipelined signed Q24.8 fixed-point ALU.
// Usage:
//  - req channel: one transaction = opcode, operand_a, operand_b. Accepted
//    on a clock edge with req.valid and req.ready both high.
//  - rsp channel: one transaction per request, in order: result_value,
//    compare_flag, error_flag. Taken when rsp.valid and rsp.ready are high.
//  - Pipeline: K = ceil((33 + FRACTION_BITS) / DIV_BITS_PER_STAGE) divider
//    stages (11 at the defaults). Stages: front decode, multiply / divider
//    setup, K divider stages, output register.
//  - Throughput: one transaction per cycle unless stalled; every op walks
//    the same pipe, the restoring divider stages set the depth.
//  - Stall: when rsp.valid is high and rsp.ready low the whole pipe
//    freezes and req.ready drops; nothing is lost or repeated.
//  - Reset (synchronous, active high) clears all stage valid bits; the
//    block takes a request right after reset.
//  - No configuration, no kept state between transactions.
module q24_8_fixed_point_alu_core
   import q24_alu_pkg::*;
#(
   parameter int FRACTION_BITS      = 8,
   parameter int DIV_BITS_PER_STAGE = 4
) (
   input  logic     clock,
   input  logic     reset,
   q24_req_if.sink   req,
   q24_rsp_if.source rsp
);
   localparam int F  = FRACTION_BITS;
   localparam int R  = DIV_BITS_PER_STAGE;
   localparam int QW = 33 + F;               // quotient / dividend width
   localparam int K  = (QW + R - 1) / R;     // divider stages
   localparam int TW = K * R;
   localparam int DW = 33;                   // divisor 2*|b|
   localparam int MW = (TW > 64) ? TW : 64;  // magnitude width at saturation
   localparam logic [MW-1:0] LIM_POS = MW'(33'h0_7FFF_FFFF);
   localparam logic [MW-1:0] LIM_NEG = MW'(33'h0_8000_0000);
   localparam logic [63:0]   HALF    = 64'd1 << (F - 1);

   logic      en;
   front_type front_ff;

   // stage 2: product and divider setup
   logic          s2_v_ff;
   side_type      s2_side_ff;
   logic [TW-1:0] s2_n_ff;
   logic [DW-1:0] s2_d_ff;

   logic          v_pipe    [0:K];
   side_type      side_pipe [0:K];
   logic [DW-1:0] rem_pipe  [0:K];
   logic [TW-1:0] nq_pipe   [0:K];
   logic [DW-1:0] den_pipe  [0:K];

   // output register
   logic              out_v_ff;
   logic [DATA_W-1:0] value_ff;
   logic              cmp_ff;
   logic              err_ff;
   opcode_type        op_ff;

   logic [DATA_W-1:0] value_in;
   logic              err_in;
   logic [MW-1:0]     q;
   logic              ovf;
   side_type          fs;

   // whole pipe advances unless the output holds an untaken result
   assign en        = !out_v_ff || rsp.ready;
   assign req.ready = en;

   q24_front #(.FRACTION_BITS(F)) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req.valid),
      .opcode    (req.opcode),
      .operand_a (req.operand_a),
      .operand_b (req.operand_b),
      .out_ff    (front_ff)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (en) begin
         s2_v_ff <= front_ff.valid;
      end
      if (en) begin
         s2_side_ff.op     <= front_ff.op;
         s2_side_ff.value  <= front_ff.value;
         s2_side_ff.cmp    <= front_ff.cmp;
         s2_side_ff.err    <= front_ff.err;
         s2_side_ff.neg    <= front_ff.neg;
         s2_side_ff.a_neg  <= front_ff.a_neg;
         s2_side_ff.b_zero <= front_ff.b_zero;
         s2_side_ff.prod   <= 64'(front_ff.mag_a) * 64'(front_ff.mag_b);
         // round to nearest: (2*|a|*2^F + |b|) / (2*|b|)
         s2_n_ff <= (TW'(front_ff.mag_a) << (F + 1)) + TW'(front_ff.mag_b);
         s2_d_ff <= {front_ff.mag_b, 1'b0};
      end
   end

   assign v_pipe[0]    = s2_v_ff;
   assign side_pipe[0] = s2_side_ff;
   assign rem_pipe[0]  = '0;
   assign nq_pipe[0]   = s2_n_ff;
   assign den_pipe[0]  = s2_d_ff;

   for (genvar g = 0; g < K; g++) begin : g_div
      q24_div_stage #(.TW(TW), .DW(DW), .R(R)) u_stage (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .v_in    (v_pipe[g]),
         .side_in (side_pipe[g]),
         .rem_in  (rem_pipe[g]),
         .nq_in   (nq_pipe[g]),
         .den_in  (den_pipe[g]),
         .v_ff    (v_pipe[g+1]),
         .side_ff (side_pipe[g+1]),
         .rem_ff  (rem_pipe[g+1]),
         .nq_ff   (nq_pipe[g+1]),
         .den_ff  (den_pipe[g+1])
      );
   end

   // final rounding / saturation for mul and div
   always_comb begin
      fs       = side_pipe[K];
      value_in = fs.value;
      err_in   = fs.err;
      q        = '0;
      if (fs.op == OP_MUL) begin
         q = MW'((fs.prod + HALF) >> F);
      end else begin
         q = MW'(nq_pipe[K]);
      end
      ovf = fs.neg ? (q > LIM_NEG) : (q > LIM_POS);
      if (fs.op == OP_MUL || fs.op == OP_DIV) begin
         if (fs.op == OP_DIV && fs.b_zero) begin
            err_in   = 1'b1;
            value_in = fs.a_neg ? SAT_MIN : SAT_MAX;
         end else if (ovf) begin
            err_in   = 1'b1;
            value_in = fs.neg ? SAT_MIN : SAT_MAX;
         end else begin
            err_in   = 1'b0;
            value_in = fs.neg ? (~q[DATA_W-1:0] + 1'b1) : q[DATA_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en) begin
         out_v_ff <= v_pipe[K];
      end
      if (en) begin
         value_ff <= value_in;
         cmp_ff   <= fs.cmp;
         err_ff   <= err_in;
         op_ff    <= fs.op;
      end
   end

   assign rsp.valid        = out_v_ff;
   assign rsp.result_value = value_ff;
   assign rsp.compare_flag = cmp_ff;
   assign rsp.error_flag   = err_ff;

`ifndef NO_ASSERTIONS
   // compares carry a zero value and never an error
   a_cmp_clean: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && (op_ff == OP_EQ || op_ff == OP_NE || op_ff == OP_LT ||
                    op_ff == OP_LE || op_ff == OP_GT || op_ff == OP_GE))
      |-> (value_ff == '0 && !err_ff))
      else $error("compare result carries value or error");

   // only compares raise the compare flag
   a_flag_only_cmp: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && cmp_ff) |->
      (op_ff == OP_EQ || op_ff == OP_NE || op_ff == OP_LT ||
       op_ff == OP_LE || op_ff == OP_GT || op_ff == OP_GE))
      else $error("compare flag on non-compare op");

   // to_int never saturates
   a_to_int_no_err: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && op_ff == OP_TO_INT) |-> !err_ff)
      else $error("to_int flagged an error");

   // a held result stays put while the pipe is frozen
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && !rsp.ready) |=> (out_v_ff && $stable(value_ff) && $stable(err_ff)))
      else $error("output changed during stall");
`endif
endmodule
